@@ rtl/core/cagp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cagp_pkg;

  // Map table depth and bar width limit
  localparam int unsigned DefMapEntries = 1024;
  localparam int unsigned MaxBarWidth   = 4096;

  // Register reset values
  localparam logic [31:0] RstStartColor = 32'h0000_00FF;
  localparam logic [31:0] RstMidColor   = 32'hFF00_00FF;
  localparam logic [31:0] RstEndColor   = 32'hFFFF_FFFF;
  localparam logic [7:0]  RstDarkLevel  = 8'h5F;
  localparam logic [7:0]  RstLightLevel = 8'hA0;
  localparam logic [7:0]  RstCheckMask  = 8'h08;
  localparam logic [11:0] RstBarWidth   = 12'd96;

  // Gradient slopes: two segments of four channels each
  localparam int unsigned NumSlopes = 8;

  // Configuration register indexes
  typedef enum logic [3:0] {
    CfgStartColor = 4'd0,
    CfgMidColor   = 4'd1,
    CfgEndColor   = 4'd2,
    CfgDarkLevel  = 4'd3,
    CfgLightLevel = 4'd4,
    CfgCheckMask  = 4'd5,
    CfgBarWidth   = 4'd6,
    CfgUseMap     = 4'd7
  } cfg_idx_e;

  // Input item commands
  typedef enum logic {
    CmdRender   = 1'b0,
    CmdMapWrite = 1'b1
  } cmd_e;

  // Blend one channel over the background, dividing by 255 through x + x/256 with rounding
  function automatic logic [7:0] blend_ch(logic [7:0] c, logic [7:0] bg, logic [7:0] alpha);
    logic signed [8:0]  diff;
    logic signed [17:0] f;
    logic signed [17:0] t;
    diff = $signed({1'b0, c}) - $signed({1'b0, bg});
    f    = 18'(diff * $signed({1'b0, alpha}));
    t    = f + (f >>> 8) + 18'sd128;
    return bg + t[15:8];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/checker_alpha_gradient_pixel.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Color bar pixel generator: gradient or map color, alpha-blended over a checkerboard.
// Input stream (s_axis): tuser = command (render or map write), tdata = column, row,
// map_index, map_entry. A render item yields one RGB pixel on m_axis; a map write
// stores map_entry into the map table and yields nothing.
// Configuration channel (cfg_*): one register per transfer, always ready.
// Throughput: one item per clock while the divider is idle and m_axis is not stalled.
// A render item passes the stage register (loads at the transfer edge), then the map read /
// gradient multiply register, then the output register.
// Each stage advances when the one after it is empty or moving, so a stalled receiver
// holds the output register while earlier stages keep filling; backpressure drops
// s_axis_tready only once all three are full.
// Slopes and the map step are quotients that a shared restoring divider (one bit per
// cycle) recomputes after reset and after each configuration write: nine quotients in
// turn, during which s_axis_tready is low. The map table keeps no reset value; an entry
// is valid once written.
module checker_alpha_gradient_pixel
  import cagp_pkg::*;
#(
  parameter int unsigned MAP_ENTRIES = DefMapEntries
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // column[11:0], row[19:12], map_index[29:20],
                                          // map_entry[61:30], zero[63:62]
  input  wire logic        s_axis_tuser,  // command[0]
  // master stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
  // configuration write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int unsigned AW  = $clog2(MAP_ENTRIES);
  localparam int unsigned SW  = AW + 16;
  localparam int unsigned MW  = AW + 12;
  localparam int unsigned DVW = (AW + 17 > 24) ? AW + 17 : 24;
  localparam int unsigned CW  = $clog2(DVW + 1);
  localparam logic [DVW-1:0] MapNum = DVW'(64'(MAP_ENTRIES) << 16);
  localparam logic [3:0] OpMapStep = 4'(NumSlopes);

  typedef enum logic [1:0] {
    DivIdle,
    DivLoad,
    DivRun
  } div_state_e;

  // ---------------------------------------------------------------- configuration
  logic [31:0] start_q, mid_q, end_q;
  logic [7:0]  dark_q, light_q, mask_q;
  logic [11:0] width_q;
  logic        use_map_q;
  logic        cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // Update the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= RstStartColor;
      mid_q     <= RstMidColor;
      end_q     <= RstEndColor;
      dark_q    <= RstDarkLevel;
      light_q   <= RstLightLevel;
      mask_q    <= RstCheckMask;
      width_q   <= RstBarWidth;
      use_map_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgStartColor: start_q   <= cfg_data_i;
        CfgMidColor:   mid_q     <= cfg_data_i;
        CfgEndColor:   end_q     <= cfg_data_i;
        CfgDarkLevel:  dark_q    <= cfg_data_i[7:0];
        CfgLightLevel: light_q   <= cfg_data_i[7:0];
        CfgCheckMask:  mask_q    <= cfg_data_i[7:0];
        CfgBarWidth:   width_q   <= cfg_data_i[11:0];
        CfgUseMap:     use_map_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Clamp the bar width and take its half
  logic [11:0] w_eff, half;

  always_comb begin
    w_eff = width_q;
    if (width_q < 12'd2) begin
      w_eff = 12'd2;
    end else if (32'(width_q) > MaxBarWidth) begin
      w_eff = 12'(MaxBarWidth);
    end
  end

  assign half = {1'b0, w_eff[11:1]};

  // ---------------------------------------------------------------- slope divider
  div_state_e       div_state_q;
  logic [3:0]       op_q;
  logic [CW-1:0]    cnt_q;
  logic [12:0]      rem_q;
  logic [DVW-1:0]   quo_q;
  logic [11:0]      dvs_q;
  logic             neg_q;
  logic signed [24:0] slope_q [NumSlopes];
  logic [SW-1:0]    step_q;

  logic [31:0]      op_from, op_to;
  logic [7:0]       op_from_ch, op_to_ch, op_mag;
  logic signed [8:0] op_diff;
  logic [DVW-1:0]   op_num;
  logic [11:0]      op_dvs;
  logic             op_neg;
  logic [12:0]      rem_sh, rem_n;
  logic             q_bit;
  logic [DVW-1:0]   quo_n;
  logic             div_last;

  // Select the operands of the current quotient
  always_comb begin
    op_from    = op_q[2] ? mid_q : start_q;
    op_to      = op_q[2] ? end_q : mid_q;
    op_from_ch = 8'(op_from >> {~op_q[1:0], 3'b000});
    op_to_ch   = 8'(op_to >> {~op_q[1:0], 3'b000});
    op_diff    = $signed({1'b0, op_to_ch}) - $signed({1'b0, op_from_ch});
    op_mag     = op_diff[8] ? 8'(-op_diff) : op_diff[7:0];
    if (op_q == OpMapStep) begin
      op_num = MapNum;
      op_dvs = w_eff;
      op_neg = 1'b0;
    end else begin
      op_num = DVW'({op_mag, 16'h0000});
      op_dvs = half;
      op_neg = op_diff[8];
    end
  end

  // One restoring step
  assign rem_sh   = {rem_q[11:0], quo_q[DVW-1]};
  assign q_bit    = rem_sh >= {1'b0, dvs_q};
  assign rem_n    = q_bit ? rem_sh - {1'b0, dvs_q} : rem_sh;
  assign quo_n    = {quo_q[DVW-2:0], q_bit};
  assign div_last = (div_state_q == DivRun) && (cnt_q == '0);

  // Sequence the nine quotients; restart on any configuration write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_state_q <= DivLoad;
      op_q        <= '0;
      cnt_q       <= '0;
    end else if (cfg_wr) begin
      div_state_q <= DivLoad;
      op_q        <= '0;
    end else begin
      unique case (div_state_q)
        DivLoad: begin
          div_state_q <= DivRun;
          cnt_q       <= CW'(DVW - 1);
        end
        DivRun: begin
          if (cnt_q == '0) begin
            if (op_q == OpMapStep) begin
              div_state_q <= DivIdle;
            end else begin
              div_state_q <= DivLoad;
              op_q        <= op_q + 4'd1;
            end
          end else begin
            cnt_q <= cnt_q - CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Divider datapath and quotient results
  always_ff @(posedge clk_i) begin
    if (div_state_q == DivLoad) begin
      rem_q <= '0;
      quo_q <= op_num;
      dvs_q <= op_dvs;
      neg_q <= op_neg;
    end else if (div_state_q == DivRun) begin
      rem_q <= rem_n;
      quo_q <= quo_n;
    end
    if (div_last) begin
      if (op_q == OpMapStep) begin
        step_q <= quo_n[SW-1:0];
      end else begin
        slope_q[op_q[2:0]] <= neg_q ? -$signed({1'b0, quo_n[23:0]})
                                    :  $signed({1'b0, quo_n[23:0]});
      end
    end
  end

  // ---------------------------------------------------------------- pipeline control
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  logic in_acc;

  assign en3           = !v3_q || m_axis_tready;
  assign en2           = !v2_q || en3;
  assign en1           = !v1_q || en2;
  assign s_axis_tready = en1 && (div_state_q == DivIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_acc && (cmd_e'(s_axis_tuser) == CmdRender);
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // ---------------------------------------------------------------- stage 1: position
  logic [11:0] in_col;
  logic [7:0]  in_row;
  logic [9:0]  in_idx;
  logic [31:0] in_entry;
  logic [11:0] pos, steps;
  logic        seg;
  logic [7:0]  bg;

  assign in_col   = s_axis_tdata[11:0];
  assign in_row   = s_axis_tdata[19:12];
  assign in_idx   = s_axis_tdata[29:20];
  assign in_entry = s_axis_tdata[61:30];

  always_comb begin
    pos   = (in_col < w_eff) ? in_col : w_eff - 12'd1;
    seg   = pos >= half;
    steps = seg ? pos - half : pos;
    bg    = (((in_col[7:0] & mask_q) ^ (in_row & mask_q)) != 8'h00) ? dark_q : light_q;
  end

  logic [11:0] pos1_q, steps1_q;
  logic        seg1_q;
  logic [7:0]  bg1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      pos1_q   <= pos;
      steps1_q <= steps;
      seg1_q   <= seg;
      bg1_q    <= bg;
    end
  end

  // ---------------------------------------------------------------- map table
  logic          map_we;
  logic [11+SW:0] map_prod;
  logic [MW-1:0] map_mi;
  logic [AW-1:0] map_raddr;
  logic [31:0]   map_rdata;

  assign map_we    = in_acc && (cmd_e'(s_axis_tuser) == CmdMapWrite)
                     && (32'(in_idx) < 32'(MAP_ENTRIES));
  assign map_prod  = (12 + SW)'(pos1_q) * (12 + SW)'(step_q);
  assign map_mi    = map_prod[11+SW:16];
  assign map_raddr = (map_mi >= MW'(MAP_ENTRIES)) ? AW'(MAP_ENTRIES - 1) : map_mi[AW-1:0];

  cagp_ram #(
    .Width (32),
    .Depth (MAP_ENTRIES)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (AW'(in_idx)),
    .wdata_i (in_entry),
    .re_i    (en2),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  // ---------------------------------------------------------------- stage 2: gradient
  logic [31:0]        g_from;
  logic [7:0]         g_from_ch [4];
  logic signed [24:0] g_slope [4];
  logic signed [37:0] g_prod [4];
  logic signed [37:0] g_val [4];
  logic [31:0]        grad;

  always_comb begin
    g_from = seg1_q ? mid_q : start_q;
    for (int c = 0; c < 4; c++) begin
      g_from_ch[c] = g_from[8*(3-c) +: 8];
      g_slope[c]   = seg1_q ? slope_q[4+c] : slope_q[c];
      g_prod[c]    = $signed({1'b0, steps1_q}) * g_slope[c];
      g_val[c]     = $signed({14'h0000, g_from_ch[c], 16'h0000}) + g_prod[c];
      grad[8*(3-c) +: 8] = g_val[c][37] ? 8'h00 : g_val[c][23:16];
    end
  end

  logic [31:0] grad2_q;
  logic [7:0]  bg2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      grad2_q <= grad;
      bg2_q   <= bg1_q;
    end
  end

  // ---------------------------------------------------------------- stage 3: blend
  logic [31:0] rgba;
  logic [23:0] pix;

  assign rgba = use_map_q ? map_rdata : grad2_q;
  assign pix  = {blend_ch(rgba[15:8], bg2_q, rgba[7:0]),
                 blend_ch(rgba[23:16], bg2_q, rgba[7:0]),
                 blend_ch(rgba[31:24], bg2_q, rgba[7:0])};

  logic [23:0] out_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      out_q <= pix;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

@@ rtl/core/cagp_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cagp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port, and a registered read that returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
